// ----- hw/rtl/cmns_pkg.sv -----
`timescale 1ns / 1ps
package cmns_pkg;

   localparam int MAX_FACE_DIM = 128;
   localparam int FACE_COUNT   = 6;
   localparam int DIM_W        = $clog2(MAX_FACE_DIM);
   localparam int SIZE_W       = $clog2(MAX_FACE_DIM + 1);
   localparam int FACE_W       = 3;
   localparam int ADDR_W       = $clog2(FACE_COUNT * MAX_FACE_DIM * MAX_FACE_DIM);
   localparam int MAG_W        = 16;
   localparam int NUM_W        = MAG_W + 1 + SIZE_W;
   localparam int DEN_W        = MAG_W + 1;
   localparam int QUO_W        = NUM_W;
   localparam logic [31:0] DEBUG_COLOR = 32'hff0000ff;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_W      = $clog2(Q_DEPTH);

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_FACE_WIDTH  = 1'b0,
      CSR_FACE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [FACE_W-1:0] FACE_XP = 3'd0;
   localparam logic [FACE_W-1:0] FACE_XN = 3'd1;
   localparam logic [FACE_W-1:0] FACE_ZP = 3'd2;
   localparam logic [FACE_W-1:0] FACE_ZN = 3'd3;
   localparam logic [FACE_W-1:0] FACE_YN = 3'd4;
   localparam logic [FACE_W-1:0] FACE_YP = 3'd5;

   typedef struct packed {
      logic              opcode;
      logic [2:0]        face_sel;
      logic [6:0]        texel_col;
      logic [6:0]        texel_row;
      logic [31:0]       texel_value;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [31:0] color;
      logic [2:0]  face_hit;
      logic        bad_direction;
   } rsp_type;

   // front to back: classified item
   typedef struct packed {
      logic              is_write;
      logic              bad;
      logic [FACE_W-1:0] face;
      logic [MAG_W-1:0]  ma;
      logic [MAG_W:0]    nu;    // a + ma, 0..2*ma
      logic [MAG_W:0]    nv;
      logic [6:0]        wcol;
      logic [6:0]        wrow;
      logic [31:0]       wdata;
   } job_type;

endpackage

// ----- hw/rtl/cmns_front.sv -----
`timescale 1ns / 1ps
module cmns_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cmns_pkg::req_type in_item,
   input  logic             stall,
   output logic             out_valid,
   output cmns_pkg::job_type out_job
);
   import cmns_pkg::*;

   logic                 valid_ff;
   job_type              job_ff;
   job_type              job_in;
   logic signed [MAG_W:0] x, y, z, au, av;
   logic [MAG_W-1:0]     ax, ay, az;

   // classify major axis and face
   always_comb begin
      x  = {in_item.dir_x[MAG_W-1], in_item.dir_x};
      y  = {in_item.dir_y[MAG_W-1], in_item.dir_y};
      z  = {in_item.dir_z[MAG_W-1], in_item.dir_z};
      ax = x[MAG_W] ? MAG_W'(-x) : x[MAG_W-1:0];
      ay = y[MAG_W] ? MAG_W'(-y) : y[MAG_W-1:0];
      az = z[MAG_W] ? MAG_W'(-z) : z[MAG_W-1:0];
      job_in          = '0;
      job_in.is_write = (in_item.opcode == OP_WRITE);
      job_in.wcol     = in_item.texel_col;
      job_in.wrow     = in_item.texel_row;
      job_in.wdata    = in_item.texel_value;
      au = '0;
      av = '0;
      if (job_in.is_write) begin
         job_in.face = in_item.face_sel;
      end else if (ax == '0 && ay == '0 && az == '0) begin
         job_in.bad = 1'b1;
      end else if (az >= ax && az >= ay) begin
         job_in.ma = az;
         if (!z[MAG_W]) begin
            job_in.face = FACE_ZP; au = -x; av = -y;
         end else begin
            job_in.face = FACE_ZN; au = x;  av = -y;
         end
      end else if (ay >= ax) begin
         job_in.ma = ay;
         if (!y[MAG_W]) begin
            job_in.face = FACE_YP; au = -x; av = z;
         end else begin
            job_in.face = FACE_YN; au = x;  av = z;
         end
      end else begin
         job_in.ma = ax;
         if (!x[MAG_W]) begin
            job_in.face = FACE_XP; au = z;  av = -y;
         end else begin
            job_in.face = FACE_XN; au = -z; av = -y;
         end
      end
      job_in.nu = (MAG_W+1)'(au + $signed({1'b0, job_in.ma}));
      job_in.nv = (MAG_W+1)'(av + $signed({1'b0, job_in.ma}));
   end

   // hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= in_valid;
      end
      if (!stall) begin
         job_ff <= job_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_job   = job_ff;
endmodule

// ----- hw/rtl/cmns_queue.sv -----
`timescale 1ns / 1ps
module cmns_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmns_pkg::job_type push_job,
   input  logic              pop,
   output logic              empty,
   output logic              almost_full,
   output cmns_pkg::job_type head
);
   import cmns_pkg::*;

   job_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, rd_ff;
   logic [Q_PTR_W:0]     cnt_ff;

   // store, advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_job;
   end

   assign empty       = (cnt_ff == '0);
   // one slot kept for the item already in the front register
   assign almost_full = (cnt_ff >= (Q_PTR_W+1)'(Q_DEPTH - 1));
   assign head        = mem_ff[rd_ff];
endmodule

// ----- hw/rtl/cmns_back.sv -----
`timescale 1ns / 1ps
module cmns_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        face_width,
   input  logic [7:0]        face_height,
   input  logic              job_valid,
   input  cmns_pkg::job_type job,
   output logic              job_take,
   output logic              rsp_valid,
   output cmns_pkg::rsp_type rsp_item,
   input  logic              rsp_take
);
   import cmns_pkg::*;

   // number of divide steps, one per quotient bit
   localparam int STG = QUO_W;

   logic [SIZE_W-1:0] sw, sh;
   logic              adv;
   logic [31:0]       store [FACE_COUNT * MAX_FACE_DIM * MAX_FACE_DIM];

   // pipeline: s0 multiply, divider load, STG divide steps, wrap and address, read into out
   logic              m_v_ff, m_bad_ff;
   logic [FACE_W-1:0] m_face_ff;
   logic [DEN_W-1:0]  m_den_ff;
   logic [NUM_W-1:0]  m_nu_ff, m_nv_ff;
   logic [SIZE_W-1:0] m_sw_ff, m_sh_ff;
   logic              m_wr_ff;
   logic [ADDR_W-1:0] m_wa_ff;
   logic [31:0]       m_wd_ff;

   logic              d_v_ff   [STG+1];
   logic              d_bad_ff [STG+1];
   logic [FACE_W-1:0] d_face_ff[STG+1];
   logic [DEN_W-1:0]  d_den_ff [STG+1];
   logic [SIZE_W-1:0] d_sw_ff  [STG+1];
   logic [SIZE_W-1:0] d_sh_ff  [STG+1];
   logic [NUM_W-1:0]  d_ru_ff  [STG+1];
   logic [NUM_W-1:0]  d_rv_ff  [STG+1];
   logic [QUO_W-1:0]  d_qu_ff  [STG+1];
   logic [QUO_W-1:0]  d_qv_ff  [STG+1];
   logic [NUM_W-1:0]  d_nu_ff  [STG+1];
   logic [NUM_W-1:0]  d_nv_ff  [STG+1];
   logic              d_wr_ff  [STG+1];
   logic [ADDR_W-1:0] d_wa_ff  [STG+1];
   logic [31:0]       d_wd_ff  [STG+1];

   logic              r_v_ff, r_bad_ff, r_wr_ff;
   logic [FACE_W-1:0] r_face_ff;
   logic [ADDR_W-1:0] r_addr_ff;
   logic [31:0]       r_wd_ff;
   logic              o_v_ff, o_bad_ff;
   logic [FACE_W-1:0] o_face_ff;
   logic [31:0]       o_data_ff;

   logic              sk_v_ff;
   rsp_type           sk_ff;
   logic [DIM_W-1:0]  col, row;
   logic [QUO_W-1:0]  qu, qv;
   logic [ADDR_W-1:0] waddr;

   // clamp sizes
   always_comb begin
      sw = (face_width == 8'd0) ? SIZE_W'(1) :
           (face_width > 8'(MAX_FACE_DIM)) ? SIZE_W'(MAX_FACE_DIM) : SIZE_W'(face_width);
      sh = (face_height == 8'd0) ? SIZE_W'(1) :
           (face_height > 8'(MAX_FACE_DIM)) ? SIZE_W'(MAX_FACE_DIM) : SIZE_W'(face_height);
   end

   // whole pipe stalls when the output skid slot is full
   assign adv      = !sk_v_ff;
   assign job_take = job_valid && adv;
   assign waddr    = ADDR_W'((32'(job.face) * MAX_FACE_DIM + 32'(job.wrow)) * MAX_FACE_DIM
                     + 32'(job.wcol));

   // multiply stage; writes ride along so they reach the store in item order
   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff  <= 1'b0;
         m_wr_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff  <= job_take && !job.is_write;
         m_wr_ff <= job_take && job.is_write && job.face < 3'(FACE_COUNT);
      end
      if (adv) begin
         m_bad_ff  <= job.bad;
         m_face_ff <= job.bad ? '0 : job.face;
         m_den_ff  <= {job.ma, 1'b0};
         m_nu_ff   <= NUM_W'(job.nu) * NUM_W'(sw);
         m_nv_ff   <= NUM_W'(job.nv) * NUM_W'(sh);
         m_sw_ff   <= sw;
         m_sh_ff   <= sh;
         m_wa_ff   <= waddr;
         m_wd_ff   <= job.wdata;
      end
   end

   // restoring divide, one quotient bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STG; i++) begin
            d_v_ff[i]  <= 1'b0;
            d_wr_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         d_v_ff[0]  <= m_v_ff;
         d_wr_ff[0] <= m_wr_ff;
         for (int i = 1; i <= STG; i++) begin
            d_v_ff[i]  <= d_v_ff[i-1];
            d_wr_ff[i] <= d_wr_ff[i-1];
         end
      end
      if (adv) begin
         d_bad_ff[0]  <= m_bad_ff;
         d_face_ff[0] <= m_face_ff;
         d_den_ff[0]  <= m_bad_ff ? DEN_W'(1) : m_den_ff;
         d_sw_ff[0]   <= m_sw_ff;
         d_sh_ff[0]   <= m_sh_ff;
         d_ru_ff[0]   <= '0;
         d_rv_ff[0]   <= '0;
         d_qu_ff[0]   <= '0;
         d_qv_ff[0]   <= '0;
         d_nu_ff[0]   <= m_nu_ff;
         d_nv_ff[0]   <= m_nv_ff;
         d_wa_ff[0]   <= m_wa_ff;
         d_wd_ff[0]   <= m_wd_ff;
         for (int i = 1; i <= STG; i++) begin
            logic [NUM_W:0] tu, tv;
            tu = {d_ru_ff[i-1], d_nu_ff[i-1][NUM_W-1]};
            tv = {d_rv_ff[i-1], d_nv_ff[i-1][NUM_W-1]};
            d_bad_ff[i]  <= d_bad_ff[i-1];
            d_face_ff[i] <= d_face_ff[i-1];
            d_den_ff[i]  <= d_den_ff[i-1];
            d_sw_ff[i]   <= d_sw_ff[i-1];
            d_sh_ff[i]   <= d_sh_ff[i-1];
            d_nu_ff[i]   <= d_nu_ff[i-1] << 1;
            d_nv_ff[i]   <= d_nv_ff[i-1] << 1;
            d_wa_ff[i]   <= d_wa_ff[i-1];
            d_wd_ff[i]   <= d_wd_ff[i-1];
            if (tu >= (NUM_W+1)'(d_den_ff[i-1])) begin
               d_ru_ff[i] <= NUM_W'(tu - (NUM_W+1)'(d_den_ff[i-1]));
               d_qu_ff[i] <= {d_qu_ff[i-1][QUO_W-2:0], 1'b1};
            end else begin
               d_ru_ff[i] <= NUM_W'(tu);
               d_qu_ff[i] <= {d_qu_ff[i-1][QUO_W-2:0], 1'b0};
            end
            if (tv >= (NUM_W+1)'(d_den_ff[i-1])) begin
               d_rv_ff[i] <= NUM_W'(tv - (NUM_W+1)'(d_den_ff[i-1]));
               d_qv_ff[i] <= {d_qv_ff[i-1][QUO_W-2:0], 1'b1};
            end else begin
               d_rv_ff[i] <= NUM_W'(tv);
               d_qv_ff[i] <= {d_qv_ff[i-1][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // quotient is at most size, so the wrap is one compare
   always_comb begin
      qu  = d_qu_ff[STG];
      qv  = d_qv_ff[STG];
      col = (qu >= QUO_W'(d_sw_ff[STG])) ? '0 : DIM_W'(qu);
      row = (qv >= QUO_W'(d_sh_ff[STG])) ? '0 : DIM_W'(qv);
   end

   // address stage, then output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff  <= 1'b0;
         r_wr_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else if (adv) begin
         r_v_ff  <= d_v_ff[STG];
         r_wr_ff <= d_wr_ff[STG];
         o_v_ff  <= r_v_ff;
      end
      if (adv) begin
         r_bad_ff  <= d_bad_ff[STG];
         r_face_ff <= d_face_ff[STG];
         r_wd_ff   <= d_wd_ff[STG];
         r_addr_ff <= d_wr_ff[STG] ? d_wa_ff[STG] :
                      ADDR_W'((32'(d_face_ff[STG]) * MAX_FACE_DIM + 32'(row)) * MAX_FACE_DIM
                      + 32'(col));
         o_bad_ff  <= r_bad_ff;
         o_face_ff <= r_face_ff;
      end
   end

   // one store access per cycle while the pipe advances: write or read at the address stage
   always_ff @(posedge clock) begin
      if (adv) begin
         if (r_wr_ff) store[r_addr_ff] <= r_wd_ff;
         o_data_ff <= store[r_addr_ff];
      end
   end

   // skid slot catches the output when the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         sk_v_ff <= 1'b0;
      end else if (sk_v_ff) begin
         if (rsp_take) sk_v_ff <= 1'b0;
      end else if (o_v_ff && !rsp_take) begin
         sk_v_ff <= 1'b1;
      end
      if (!sk_v_ff) begin
         sk_ff.color         <= o_bad_ff ? DEBUG_COLOR : o_data_ff;
         sk_ff.face_hit      <= o_face_ff;
         sk_ff.bad_direction <= o_bad_ff;
      end
   end

   assign rsp_valid = sk_v_ff || o_v_ff;
   always_comb begin
      if (sk_v_ff) begin
         rsp_item = sk_ff;
      end else begin
         rsp_item.color         = o_bad_ff ? DEBUG_COLOR : o_data_ff;
         rsp_item.face_hit      = o_face_ff;
         rsp_item.bad_direction = o_bad_ff;
      end
   end
endmodule

// ----- hw/rtl/cube_map_nearest_sampler_core.sv -----
`timescale 1ns / 1ps
// Nearest-texel cube map sampler. Write items fill a 6x128x128 texel store;
// sample items return one texel each, in order. A new item is taken every
// cycle while the results are drained; a sample passes front classify,
// queue, multiply, a 25-step pipelined divider with its load stage,
// address and store read before empty goes low. Write items give no
// result; they travel down the same pipeline and reach the store at the
// address stage, so each sample sees exactly the writes pushed before it.
// A result left unread parks in a skid slot and holds the whole pipeline
// until popped. The store has no reset contents.
module cube_map_nearest_sampler_core
   import cmns_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_item,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_item,
   input  logic     csr_write,
   input  logic     csr_index,
   input  logic [7:0] csr_data
);
   logic [7:0] face_width_ff, face_height_ff;
   logic       f_valid, q_empty, q_afull, take, rsp_valid;
   job_type    f_job, q_head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff  <= 8'd128;
         face_height_ff <= 8'd128;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FACE_WIDTH:  face_width_ff  <= csr_data;
            CSR_FACE_HEIGHT: face_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign full = q_afull;

   cmns_front u_front (
      .clock, .reset,
      .in_valid (push && !full),
      .in_item  (req_item),
      .stall    (1'b0),
      .out_valid(f_valid),
      .out_job  (f_job)
   );

   cmns_queue u_queue (
      .clock, .reset,
      .push       (f_valid),
      .push_job   (f_job),
      .pop        (take),
      .empty      (q_empty),
      .almost_full(q_afull),
      .head       (q_head)
   );

   cmns_back u_back (
      .clock, .reset,
      .face_width (face_width_ff),
      .face_height(face_height_ff),
      .job_valid  (!q_empty),
      .job        (q_head),
      .job_take   (take),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rsp_take   (pop)
   );

   assign empty = !rsp_valid;
endmodule

// ----- hw/rtl/cmns_checker.sv -----
`timescale 1ns / 1ps
module cmns_checker
   import cmns_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_item
);
   // reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result after reset");

   // a bad direction always carries the debug color on face 0
   a_bad_color: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.bad_direction) |->
      (rsp_item.color == DEBUG_COLOR && rsp_item.face_hit == '0))
      else $error("bad direction payload");

   // face stays in range
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.face_hit < 3'(FACE_COUNT)))
      else $error("face out of range");

   // a waiting result holds while not popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("result dropped");
endmodule

bind cube_map_nearest_sampler_core cmns_checker u_checker (
   .clock, .reset, .empty, .pop, .rsp_item
);

// ----- sim/cube_map_nearest_sampler_core_tb.sv -----
`timescale 1ns / 1ps
module cube_map_nearest_sampler_core_tb;
   import cmns_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic          clock;
   logic          reset;
   logic          push;
   logic          full;
   req_type       req_item;
   logic          empty;
   logic          pop;
   rsp_type       rsp_item;
   logic          csr_write;
   logic          csr_index;
   logic [7:0]    csr_data;

   cube_map_nearest_sampler_core u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // texel shadow copy, size registers and the results still owed
   logic [31:0]   texel_mem [int];
   logic [7:0]    width_reg;
   logic [7:0]    height_reg;
   rsp_type       owed_q[$];
   int            errors;
   int            cycles;
   bit            calm;
   int            hold_req;
   int            hold_seen;
   int            hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // guard against a hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int clamp_size(logic [7:0] r);
      if (r == 0) return 1;
      if (r > MAX_FACE_DIM) return MAX_FACE_DIM;
      return r;
   endfunction

   function automatic int map_coord(int a, int ma, int size);
      longint num;
      num = longint'(a + ma) * size;
      return int'((num / (2 * ma)) % size);
   endfunction

   // pick face and texel for a sample item
   function automatic void locate(req_type r, output bit bad, output logic [2:0] face,
                                  output int col, output int row);
      int x, y, z, ax, ay, az, ma, au, av;
      x = r.dir_x; y = r.dir_y; z = r.dir_z;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      bad = (ax == 0 && ay == 0 && az == 0);
      face = FACE_XP; col = 0; row = 0;
      if (bad) return;
      if (az >= ax && az >= ay) begin
         ma = az;
         if (z > 0) begin face = FACE_ZP; au = -x; av = -y; end
         else begin face = FACE_ZN; au = x; av = -y; end
      end else if (ay >= ax) begin
         ma = ay;
         if (y > 0) begin face = FACE_YP; au = -x; av = z; end
         else begin face = FACE_YN; au = x; av = z; end
      end else begin
         ma = ax;
         if (x > 0) begin face = FACE_XP; au = z; av = -y; end
         else begin face = FACE_XN; au = -z; av = -y; end
      end
      col = map_coord(au, ma, clamp_size(width_reg));
      row = map_coord(av, ma, clamp_size(height_reg));
   endfunction

   function automatic int texel_addr(int face, int row, int col);
      return (face * MAX_FACE_DIM + row) * MAX_FACE_DIM + col;
   endfunction

   // update the shadow store or queue the sampled texel
   function automatic void predict_item(req_type r);
      rsp_type    exp_rsp;
      bit         bad;
      logic [2:0] face;
      int         col, row;
      if (r.opcode == OP_WRITE) begin
         if (r.face_sel < FACE_COUNT)
            texel_mem[texel_addr(r.face_sel, r.texel_row, r.texel_col)] = r.texel_value;
         return;
      end
      locate(r, bad, face, col, row);
      exp_rsp.bad_direction = bad;
      exp_rsp.face_hit      = face;
      if (bad) exp_rsp.color = DEBUG_COLOR;
      else exp_rsp.color = texel_mem[texel_addr(face, row, col)];
      owed_q.push_back(exp_rsp);
   endfunction

   // send one item, idling at random first
   task automatic send_item(req_type r);
      while (!calm && $urandom_range(99) < 19) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (full);
      predict_item(r);
   endtask

   task automatic stop_sending();
      push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      stop_sending();
      while (owed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type rand_req();
      req_type      r;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      return r;
   endfunction

   task automatic write_texel(int face, int row, int col, logic [31:0] v);
      req_type r;
      r = rand_req();
      r.opcode = OP_WRITE; r.face_sel = 3'(face); r.texel_row = 7'(row);
      r.texel_col = 7'(col);
      r.texel_value = v;
      send_item(r);
   endtask

   // sample, first filling the texel it will read if that one is still blank
   task automatic sample_dir(int x, int y, int z);
      req_type    r;
      bit         bad;
      logic [2:0] face;
      int         col, row;
      r = rand_req();
      r.opcode = OP_SAMPLE; r.dir_x = 16'(x); r.dir_y = 16'(y); r.dir_z = 16'(z);
      locate(r, bad, face, col, row);
      if (!bad && !texel_mem.exists(texel_addr(face, row, col)))
         write_texel(face, row, col, $urandom);
      send_item(r);
   endtask

   task automatic set_size(logic [7:0] w, logic [7:0] h);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_FACE_WIDTH;
      csr_data  <= w;
      @(posedge clock);
      csr_index <= CSR_FACE_HEIGHT;
      csr_data  <= h;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      width_reg  = w;
      height_reg = h;
   endtask

   // check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && pop && !empty) begin
         if (owed_q.size() == 0) begin
            $error("unexpected item color %h", rsp_item.color);
            errors++;
         end else begin
            exp_rsp = owed_q.pop_front();
            if (rsp_item.color !== exp_rsp.color) begin
               $error("color exp %h got %h", exp_rsp.color, rsp_item.color);
               errors++;
            end
            if (rsp_item.face_hit !== exp_rsp.face_hit) begin
               $error("face_hit exp %0d got %0d", exp_rsp.face_hit, rsp_item.face_hit);
               errors++;
            end
            if (rsp_item.bad_direction !== exp_rsp.bad_direction) begin
               $error("bad_direction exp %0d got %0d", exp_rsp.bad_direction,
                      rsp_item.bad_direction);
               errors++;
            end
         end
      end
   end

   // drive pop: random stalls, plus long holds on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 300;
         pop       <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop       <= 1'b0;
      end else begin
         pop <= calm || $urandom_range(99) >= 19;
      end
   end

   task automatic test_directed();
      req_type r;
      sample_dir(0, 0, 0);
      sample_dir(32767, 0, 0);
      sample_dir(-32768, 0, 0);
      sample_dir(0, 32767, 0);
      sample_dir(0, -32768, 0);
      sample_dir(0, 0, 32767);
      sample_dir(0, 0, -32768);
      sample_dir(5, 5, 5);
      sample_dir(-7, 7, 3);
      sample_dir(9, -9, 1);
      sample_dir(-32768, -32768, -32768);
      sample_dir(32767, -32768, 32767);
      sample_dir(100, 100, 0);
      sample_dir(4, 1, -4);
      sample_dir(-3, 2, -1);
      sample_dir(2, -3, 1);
      sample_dir(-1, 1, 2);
      // writes to faces beyond the last are dropped
      r = rand_req(); r.opcode = OP_WRITE; r.face_sel = 3'd6; send_item(r);
      r = rand_req(); r.opcode = OP_WRITE; r.face_sel = 3'd7; send_item(r);
      write_texel(5, 127, 127, 32'hffffffff);
      write_texel(0, 0, 0, 32'h0);
   endtask

   function automatic int rand_comp();
      if ($urandom_range(2) == 0) return $signed(16'($urandom));
      return $signed($urandom_range(16)) - 8;
   endfunction

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(4) == 0)
            write_texel($urandom_range(5), $urandom_range(127), $urandom_range(127),
                        $urandom);
         else
            sample_dir(rand_comp(), rand_comp(), rand_comp());
      end
   endtask

   // fill the queue behind a stalled receiver, then let it all drain
   task automatic test_backpressure();
      hold_req <= hold_req + 1;
      test_random(60);
      wait_drained();
      test_random(40);
   endtask

   initial begin
      errors = 0; cycles = 0; calm = 1'b0;
      hold_req = 0; hold_seen = 0; hold_left = 0;
      width_reg = 8'd128; height_reg = 8'd128;
      reset <= 1'b1; push <= 1'b0; pop <= 1'b0; req_item <= '0;
      csr_write <= 1'b0; csr_index <= CSR_FACE_WIDTH; csr_data <= 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(150);
      set_size(8'd1, 8'd1);
      test_directed();
      test_random(120);
      set_size(8'd0, 8'd255);
      test_random(120);
      calm = 1'b1;
      set_size(8'd3, 8'd128);
      test_random(120);
      calm = 1'b0;
      set_size(8'($urandom_range(1, 128)), 8'($urandom_range(1, 128)));
      test_backpressure();
      test_random(120);
      set_size(8'd128, 8'd7);
      test_directed();
      test_random(120);

      wait_drained();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
